// ===== rtl/prc_pkg.sv =====
`timescale 1ns / 1ps
package prc_pkg;

   typedef struct packed {
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [23:0] centroid_x;
      logic signed [23:0] centroid_y;
      logic [1:0]         result_kind;
      logic               count_overflow;
   } rsp_type;

   // Ring summary handed from the accumulator to the divider back end
   typedef struct packed {
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [47:0] area2;
      logic signed [63:0] wx;
      logic signed [63:0] wy;
      logic signed [27:0] px;
      logic signed [27:0] py;
      logic [11:0]        count;
      logic               ovf;
   } ring_type;

   localparam logic [1:0] KIND_AREA   = 2'd0;
   localparam logic [1:0] KIND_MEAN   = 2'd1;
   localparam logic [1:0] KIND_SINGLE = 2'd2;

endpackage

// ===== rtl/prc_front.sv =====
`timescale 1ns / 1ps
module prc_front import prc_pkg::*; #(
   parameter int MAX_VERTICES = 2048
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     ring_valid,
   input  logic     ring_stall,
   output ring_type ring_data
);
   // Stage 0 holds the vertex products (registered), stage 1 accumulates.
   logic               s1_ff, s1_in;
   logic               s1_last_ff;
   logic               s1_use_ff;
   logic signed [17:0] sx_ff, sy_ff;
   logic signed [33:0] d_ff;
   logic signed [15:0] fx_ff, fy_ff;
   logic signed [16:0] prx_ff, pry_ff;
   logic signed [47:0] area_ff;
   logic signed [63:0] wx_ff, wy_ff;
   logic signed [27:0] px_ff, py_ff;
   logic [11:0]        cnt_ff;
   logic               ovf_ff;
   logic               out_v_ff;
   ring_type           out_ff;
   logic               acc;
   logic signed [16:0] rx_c, ry_c;
   logic signed [47:0] area_n;
   logic signed [63:0] wx_n, wy_n;

   // Stall while a finished ring waits on a busy back end, and for the cycle
   // in which a last vertex closes its ring
   assign req_stall  = (out_v_ff & ring_stall) | (s1_ff & s1_last_ff);
   assign acc        = req_valid & ~req_stall;
   assign ring_valid = out_v_ff;
   assign ring_data  = out_ff;

   assign rx_c = 17'(req_data.vertex_x) - 17'(fx_ff);
   assign ry_c = 17'(req_data.vertex_y) - 17'(fy_ff);
   assign area_n = area_ff + 48'(d_ff);
   assign wx_n   = wx_ff + 64'(sx_ff * d_ff);
   assign wy_n   = wy_ff + 64'(sy_ff * d_ff);
   assign s1_in = acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         out_v_ff <= 1'b0;
         fx_ff <= '0; fy_ff <= '0;
         prx_ff <= '0; pry_ff <= '0;
         area_ff <= '0; wx_ff <= '0; wy_ff <= '0; px_ff <= '0; py_ff <= '0;
      end else begin
         s1_ff <= s1_in;
         if (out_v_ff & ~ring_stall) out_v_ff <= 1'b0;
         // stage 0: classify the vertex and take the cross product
         if (acc) begin
            s1_last_ff <= req_data.last_vertex;
            s1_use_ff  <= 1'b0;
            if (32'(cnt_ff) >= 32'(MAX_VERTICES)) begin
               ovf_ff <= 1'b1;
            end else if (cnt_ff == '0) begin
               fx_ff <= req_data.vertex_x;
               fy_ff <= req_data.vertex_y;
               prx_ff <= '0; pry_ff <= '0;
               sx_ff <= '0; sy_ff <= '0;
               d_ff <= '0;
               cnt_ff <= 12'd1;
            end else begin
               s1_use_ff <= 1'b1;
               sx_ff <= 18'(prx_ff) + 18'(rx_c);
               sy_ff <= 18'(pry_ff) + 18'(ry_c);
               d_ff  <= 34'(prx_ff * ry_c) - 34'(rx_c * pry_ff);
               px_ff <= px_ff + 28'(fx_ff) + 28'(prx_ff);
               py_ff <= py_ff + 28'(fy_ff) + 28'(pry_ff);
               prx_ff <= rx_c;
               pry_ff <= ry_c;
               cnt_ff <= cnt_ff + 12'd1;
            end
         end
         // stage 1: weight and accumulate, close the ring on its last vertex
         if (s1_ff) begin
            if (s1_last_ff) begin
               out_v_ff      <= 1'b1;
               out_ff.first_x <= fx_ff;
               out_ff.first_y <= fy_ff;
               out_ff.area2  <= s1_use_ff ? area_n : area_ff;
               out_ff.wx     <= s1_use_ff ? wx_n : wx_ff;
               out_ff.wy     <= s1_use_ff ? wy_n : wy_ff;
               out_ff.px     <= px_ff;
               out_ff.py     <= py_ff;
               out_ff.count  <= cnt_ff;
               out_ff.ovf    <= ovf_ff;
               cnt_ff <= '0; ovf_ff <= 1'b0;
               fx_ff <= '0; fy_ff <= '0; prx_ff <= '0; pry_ff <= '0;
               area_ff <= '0; wx_ff <= '0; wy_ff <= '0; px_ff <= '0; py_ff <= '0;
            end else if (s1_use_ff) begin
               area_ff <= area_n;
               wx_ff   <= wx_n;
               wy_ff   <= wy_n;
            end
         end
      end
   end
endmodule

// ===== rtl/prc_back.sv =====
`timescale 1ns / 1ps
module prc_back import prc_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [20:0] threshold,
   input  logic        ring_valid,
   output logic        ring_stall,
   input  ring_type    ring_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_FIN  = 3'd2;
   localparam logic [2:0] ST_OUT  = 3'd3;
   localparam int QW = 64 + FRAC_BITS + 1;   // quotient bits incl. one rounding bit

   logic [2:0]   st_ff;
   ring_type     r_ff;
   logic [1:0]   kind_ff;
   logic         axis_ff;              // 0: x, 1: y
   logic [65:0]  den_ff;               // magnitude of divisor
   logic [65:0]  rem_ff;
   logic [QW-1:0] num_ff;              // shifted dividend, becomes quotient
   logic [6:0]   bit_ff;
   logic         neg_ff;
   logic signed [23:0] cx_ff;
   rsp_type      out_ff;
   logic signed [49:0] den3;
   logic [65:0]  rtry;
   logic [64:0]  qfull;
   logic [66:0]  qres;
   logic signed [67:0] val;
   logic signed [23:0] sat;
   logic signed [63:0] nsel;
   logic [63:0]  nmag;

   assign ring_stall = (st_ff != ST_IDLE);
   assign rsp_valid  = (st_ff == ST_OUT);
   assign rsp_data   = out_ff;
   assign den3 = 50'(r_ff.area2) * 50'sd3;

   // restoring divide step on the shifted magnitude
   assign rtry = {rem_ff[64:0], num_ff[QW-1]};

   // numerator of the next axis
   always_comb begin
      if (kind_ff == KIND_MEAN) nsel = axis_ff ? 64'(r_ff.py) : 64'(r_ff.px);
      else nsel = axis_ff ? r_ff.wy : r_ff.wx;
      nmag = nsel[63] ? 64'(-nsel) : nsel;
   end

   // quotient with half-bit rounding; cap large quotients at 2^40
   always_comb begin
      qfull = 65'((num_ff + QW'(1)) >> 1);
      if ((num_ff >> (FRAC_BITS + 1)) >= QW'(1 << 24)) qres = 67'(1) << 40;
      else qres = 67'(qfull);
      val = neg_ff ? -68'(qres) : 68'(qres);
      if (kind_ff == KIND_AREA)
         val = val + (68'(axis_ff ? r_ff.first_y : r_ff.first_x) <<< FRAC_BITS);
      if (val > 68'sd8388607) sat = 24'sh7FFFFF;
      else if (val < -68'sd8388608) sat = -24'sh800000;
      else sat = 24'(val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         case (st_ff)
            ST_IDLE: if (ring_valid) begin
               r_ff  <= ring_data;
               axis_ff <= 1'b0;
               st_ff <= ST_FIN;
               kind_ff <= KIND_SINGLE;
               bit_ff <= '0;
               if (ring_data.count > 12'd1) begin
                  if (ring_data.area2 == '0 ||
                      (ring_data.area2[47] ? 48'(-ring_data.area2) : ring_data.area2)
                      < 48'(threshold))
                     kind_ff <= KIND_MEAN;
                  else kind_ff <= KIND_AREA;
                  st_ff <= ST_DIV;
                  bit_ff <= 7'd127;   // marks "load"
               end
            end
            ST_DIV: begin
               if (bit_ff == 7'd127) begin
                  // load operands
                  den_ff <= (kind_ff == KIND_MEAN) ? 66'(r_ff.count - 12'd1)
                          : (den3[49] ? 66'(-den3) : 66'(den3));
                  neg_ff <= nsel[63] ^ ((kind_ff == KIND_AREA) & r_ff.area2[47]);
                  num_ff <= QW'(nmag) << (FRAC_BITS + 1);
                  rem_ff <= '0;
                  bit_ff <= 7'(QW);
               end else begin
                  if (rtry >= den_ff) begin
                     rem_ff <= rtry - den_ff;
                     num_ff <= {num_ff[QW-2:0], 1'b1};
                  end else begin
                     rem_ff <= rtry;
                     num_ff <= {num_ff[QW-2:0], 1'b0};
                  end
                  bit_ff <= bit_ff - 7'd1;
                  if (bit_ff == 7'd1) st_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (kind_ff == KIND_SINGLE) begin
                  out_ff.centroid_x <= 24'(r_ff.first_x) <<< FRAC_BITS;
                  out_ff.centroid_y <= 24'(r_ff.first_y) <<< FRAC_BITS;
                  st_ff <= ST_OUT;
               end else if (!axis_ff) begin
                  cx_ff <= sat;
                  axis_ff <= 1'b1;
                  bit_ff <= 7'd127;
                  st_ff <= ST_DIV;
               end else begin
                  out_ff.centroid_x <= cx_ff;
                  out_ff.centroid_y <= sat;
                  st_ff <= ST_OUT;
               end
               out_ff.result_kind <= kind_ff;
               out_ff.count_overflow <= r_ff.ovf;
            end
            ST_OUT: if (!rsp_stall) st_ff <= ST_IDLE;
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/polygon_ring_centroid.sv =====
`timescale 1ns / 1ps
// Streaming centroid of one polygon ring.
// Input channel (req_): one vertex per item, last_vertex marks the ring end.
// Vertices are taken one per cycle unless req_stall is high; a two-stage
// shoelace accumulator builds the area and weighted sums. On the last vertex
// the ring summary moves to a register slot, and a serial divider back end
// forms the result. The input pauses for one cycle after each last vertex
// while the ring closes. Result channel (rsp_): one item per ring. A ring of
// more than one vertex is formed by one 65+FRAC_BITS step divide per axis,
// each with a load and a finish state. The back end takes no new ring until
// the result of the last one has been taken.
// A second ring may stream in while the divider works; once its last vertex
// fills the slot, further vertices wait (req_stall) until the slot is claimed.
// csr_: a write sets area_threshold; reset value is 1.
// Reset (synchronous, active high) clears the ring state and all valids.
// While rsp_stall is high the result is held unchanged.
module polygon_ring_centroid import prc_pkg::*; #(
   parameter int MAX_VERTICES = 2048,
   parameter int FRAC_BITS    = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [20:0] csr_wdata
);
   logic [20:0] thr_ff;
   logic        ring_valid, ring_stall;
   ring_type    ring_data;

   // hold the threshold register
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= 21'd1;
      else if (csr_we) thr_ff <= csr_wdata;
   end

   prc_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .ring_valid, .ring_stall, .ring_data
   );

   prc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .threshold(thr_ff), .ring_valid, .ring_stall, .ring_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

// ===== tb/sv/centroid_checker.sv =====
`timescale 1ns / 1ps
module centroid_checker import prc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [20:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   localparam int MAX_V = 2048;
   localparam int FRAC  = 8;

   // shadow of the block's register and ring state
   logic [20:0]    thresh;
   longint         fx, fy, prx, pry, area2, wxs, wys, pxs, pys;
   int unsigned    vcount;
   bit             ovf;
   rsp_type        centroid_queue[$];

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint sat24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // quotient scaled by 2^FRAC, rounded half away from zero
   function automatic longint fixed_quotient(longint num, longint den);
      longint unsigned n, d, q, r, m;
      n = mag(num);
      d = mag(den);
      q = n / d;
      r = n % d;
      if (q >= (64'd1 << 24)) m = 64'd1 << 40;
      else m = (q << FRAC) + ((2 * (r << FRAC) + d) / (2 * d));
      return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
   endfunction

   task automatic clear_ring();
      fx = 0; fy = 0; prx = 0; pry = 0; area2 = 0;
      wxs = 0; wys = 0; pxs = 0; pys = 0; vcount = 0; ovf = 0;
   endtask

   // fold one vertex in, queue a result on the ring end
   task automatic accept_vertex(req_type it);
      longint x, y, rx, ry, d, cx, cy;
      logic [1:0] kind;
      rsp_type r;
      x = it.vertex_x;
      y = it.vertex_y;
      if (vcount >= MAX_V) begin
         ovf = 1;
      end else if (vcount == 0) begin
         fx = x; fy = y; prx = 0; pry = 0; vcount = 1;
      end else begin
         rx = x - fx;
         ry = y - fy;
         d = prx * ry - rx * pry;
         area2 += d;
         wxs += (prx + rx) * d;
         wys += (pry + ry) * d;
         pxs += fx + prx;
         pys += fy + pry;
         prx = rx;
         pry = ry;
         vcount++;
      end
      if (!it.last_vertex) return;
      if (vcount <= 1) begin
         cx = fx <<< FRAC;
         cy = fy <<< FRAC;
         kind = KIND_SINGLE;
      end else if (area2 == 0 || mag(area2) < longint'(thresh)) begin
         cx = fixed_quotient(pxs, longint'(vcount) - 1);
         cy = fixed_quotient(pys, longint'(vcount) - 1);
         kind = KIND_MEAN;
      end else begin
         cx = (fx <<< FRAC) + fixed_quotient(wxs, 3 * area2);
         cy = (fy <<< FRAC) + fixed_quotient(wys, 3 * area2);
         kind = KIND_AREA;
      end
      r.centroid_x = 24'(sat24(cx));
      r.centroid_y = 24'(sat24(cy));
      r.result_kind = kind;
      r.count_overflow = ovf;
      centroid_queue.push_back(r);
      clear_ring();
   endtask

   // watch both channels at each rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         thresh = 21'd1;
         clear_ring();
         centroid_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_we) thresh = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (centroid_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result %h", rsp_data);
            end else begin
               want = centroid_queue.pop_front();
               if (rsp_data.centroid_x !== want.centroid_x ||
                   rsp_data.centroid_y !== want.centroid_y ||
                   rsp_data.result_kind !== want.result_kind ||
                   rsp_data.count_overflow !== want.count_overflow) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp x=%0d y=%0d k=%0d o=%0d got x=%0d y=%0d k=%0d o=%0d",
                        want.centroid_x, want.centroid_y, want.result_kind,
                        want.count_overflow, rsp_data.centroid_x,
                        rsp_data.centroid_y, rsp_data.result_kind,
                        rsp_data.count_overflow);
               end
            end
         end
         if (req_valid && !req_stall) accept_vertex(req_data);
      end
      pending_count = centroid_queue.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import prc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_data;
   logic        csr_we = 0;
   logic [20:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          rsp_quiet = 0;

   polygon_ring_centroid dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   centroid_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // random receiver stall runs, quiet while rsp_quiet is set
   always @(negedge clock) begin
      if (reset || rsp_quiet) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < 30) begin
         rsp_stall <= 1;
         stall_left <= gap_length();
      end else rsp_stall <= 0;
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // send one vertex, honoring gaps; valid stays up across back-to-back items
   task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last,
                              bit use_gaps);
      int g;
      g = use_gaps ? gap_length() : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_data.vertex_x <= x;
      req_data.vertex_y <= y;
      req_data.last_vertex <= last;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(logic [20:0] v);
      csr_wdata <= v;
      csr_we <= 1;
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic logic signed [15:0] rand_coord(int spread);
      if (spread >= 32768) return 16'($urandom);
      return 16'($urandom_range(2 * spread) - spread);
   endfunction

   // ring of random content; mostly small, some larger
   task automatic random_ring(ref int sent);
      int n, p, spread;
      p = $urandom_range(99);
      if (p < 10) n = 1;
      else if (p < 85) n = $urandom_range(8, 2);
      else n = $urandom_range(40, 9);
      spread = ($urandom_range(3) == 0) ? 32768 : $urandom_range(300, 1);
      for (int i = 0; i < n; i++)
         send_vertex(rand_coord(spread), rand_coord(spread), i == n - 1, 1);
      sent += n;
   endtask

   initial begin
      int sent;
      logic [20:0] thr[5];
      thr = '{21'd0, 21'd1, 21'd1000, 21'd1048576, 21'd2097151};
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: one-vertex extremes, square both ways, degenerate line, max square
      send_vertex(16'sh7FFF, -16'sh8000, 1, 0);
      send_vertex(-16'sh8000, 16'sh7FFF, 1, 0);
      send_vertex(0, 0, 0, 0);  send_vertex(10, 0, 0, 0);
      send_vertex(10, 10, 0, 0); send_vertex(0, 10, 1, 0);
      send_vertex(0, 0, 0, 0);  send_vertex(0, 10, 0, 0);
      send_vertex(10, 10, 0, 0); send_vertex(10, 0, 0, 0);
      send_vertex(0, 0, 1, 0);
      send_vertex(1, 1, 0, 0);  send_vertex(2, 2, 0, 0); send_vertex(3, 3, 1, 0);
      send_vertex(-16'sh8000, -16'sh8000, 0, 0); send_vertex(16'sh7FFF, -16'sh8000, 0, 0);
      send_vertex(16'sh7FFF, 16'sh7FFF, 0, 0);   send_vertex(-16'sh8000, 16'sh7FFF, 1, 0);
      drain();

      // zero threshold still falls back on zero area
      write_threshold(21'd0);
      send_vertex(5, 5, 0, 0); send_vertex(6, 6, 1, 0);
      send_vertex(0, 0, 0, 0); send_vertex(1, 0, 0, 0); send_vertex(0, 1, 1, 0);
      drain();

      // random phases across thresholds, receiver quiet in one of them
      sent = 0;
      for (int ph = 0; ph < 5; ph++) begin
         write_threshold(ph == 4 ? 21'($urandom_range(4000)) : thr[ph]);
         rsp_quiet = (ph == 2);
         while (sent < 254 * (ph + 1)) random_ring(sent);
         drain();
      end
      rsp_quiet = 0;

      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== polygon_ring_centroid.f =====
rtl/prc_pkg.sv
rtl/prc_front.sv
rtl/prc_back.sv
rtl/polygon_ring_centroid.sv
tb/sv/centroid_checker.sv
tb/sv/tb_top.sv
